>>> design/owh_pkg.sv
// owh_pkg: shared types, constants and functions for the one-way string hash.
// Holds the scramble table generator used by owh_rom at elaboration.
// Used by owh_rom, owh_mix and one_way_string_hash_top.
package owh_pkg;

   // Table geometry
   localparam int HashKinds    = 5;
   localparam int RomWords     = HashKinds * 256;
   localparam int RomAddrWidth = $clog2(RomWords);
   localparam int ByteWidth    = 8;
   localparam int KindWidth    = 3;
   localparam int HashWidth    = 32;

   // Seed start values
   localparam logic [HashWidth-1:0] SeedAStart = 32'h7FED7FED;
   localparam logic [HashWidth-1:0] SeedBStart = 32'hEEEEEEEE;

   // Table generator constants
   localparam logic [31:0] GenStart = 32'h00100001;
   localparam logic [31:0] GenMod   = 32'h002AAAAB;
   localparam logic [31:0] GenMul   = 32'd125;
   localparam logic [31:0] GenAdd   = 32'd3;

   // Case folding bounds
   localparam logic [ByteWidth-1:0] LowerA     = 8'h61;
   localparam logic [ByteWidth-1:0] LowerZ     = 8'h7A;
   localparam logic [ByteWidth-1:0] CaseOffset = 8'h20;

   typedef logic [HashWidth-1:0] rom_word_type;
   typedef rom_word_type rom_image_type [RomWords];

   // Control carried alongside the registered table word
   typedef struct packed {
      logic                 has_byte;
      logic                 last_byte;
      logic [ByteWidth-1:0] ch;
   } stage_ctl_type;

   // Fold ASCII lower case to upper case, pass everything else
   function automatic logic [ByteWidth-1:0] fold_upper(input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] r;
      r = b;
      if (b >= LowerA && b <= LowerZ) begin
         r = b - CaseOffset;
      end
      return r;
   endfunction

   // Map out-of-range kinds onto the last table row
   function automatic logic [KindWidth-1:0] clamp_kind(input logic [KindWidth-1:0] k);
      logic [KindWidth-1:0] r;
      r = k;
      if (32'(k) >= HashKinds) begin
         r = KindWidth'(HashKinds - 1);
      end
      return r;
   endfunction

   // Build the scramble table from the seeded modular generator
   function automatic rom_image_type build_rom();
      rom_image_type img;
      logic [31:0]   s;
      logic [15:0]   hi;
      s = GenStart;
      for (int c = 0; c < 256; c++) begin
         for (int k = 0; k < HashKinds; k++) begin
            s  = (s * GenMul + GenAdd) % GenMod;
            hi = s[15:0];
            s  = (s * GenMul + GenAdd) % GenMod;
            img[k * 256 + c] = {hi, s[15:0]};
         end
      end
      return img;
   endfunction

endpackage

>>> design/owh_rom.sv
// owh_rom: scramble table with a registered read port.
// Contents come from owh_pkg::build_rom at elaboration; depends on owh_pkg.
module owh_rom (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [owh_pkg::RomAddrWidth-1:0] rd_addr,
   output owh_pkg::rom_word_type            rd_data
);

   localparam owh_pkg::rom_image_type RomImage = owh_pkg::build_rom();

   owh_pkg::rom_word_type rd_data_ff;

   // Read on enable, hold otherwise
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= RomImage[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/owh_mix.sv
// owh_mix: running seed pair, mixing datapath and result register.
// Takes the registered table word and stage control; depends on owh_pkg.
module owh_mix (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                stage_valid,
   input  owh_pkg::stage_ctl_type              stage_ctl,
   input  owh_pkg::rom_word_type               rom_word,
   output logic                                stage_take,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [owh_pkg::HashWidth-1:0]       rsp_tdata
);

   logic [owh_pkg::HashWidth-1:0] mix_a_ff, mix_a_in;
   logic [owh_pkg::HashWidth-1:0] mix_b_ff, mix_b_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [owh_pkg::HashWidth-1:0] hash_ff, hash_in;
   logic [owh_pkg::HashWidth-1:0] new_a, new_b;
   logic                          out_free;

   // Output slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // A string end needs the output slot; other items pass straight through
   assign stage_take = stage_valid && (!stage_ctl.last_byte || out_free);

   // Mix one folded byte into the seeds
   always_comb begin
      new_a = rom_word ^ (mix_a_ff + mix_b_ff);
      new_b = {{(owh_pkg::HashWidth-owh_pkg::ByteWidth){1'b0}}, stage_ctl.ch}
              + new_a + mix_b_ff + {mix_b_ff[owh_pkg::HashWidth-6:0], 5'b0}
              + owh_pkg::HashWidth'(3);
   end

   // Seed and result update
   always_comb begin
      mix_a_in     = mix_a_ff;
      mix_b_in     = mix_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hash_in      = hash_ff;
      if (stage_take) begin
         if (stage_ctl.has_byte) begin
            mix_a_in = new_a;
            mix_b_in = new_b;
         end
         if (stage_ctl.last_byte) begin
            mix_a_in     = owh_pkg::SeedAStart;
            mix_b_in     = owh_pkg::SeedBStart;
            rsp_valid_in = 1'b1;
            hash_in      = stage_ctl.has_byte ? new_a : mix_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_a_ff     <= owh_pkg::SeedAStart;
         mix_b_ff     <= owh_pkg::SeedBStart;
         rsp_valid_ff <= 1'b0;
      end else begin
         mix_a_ff     <= mix_a_in;
         mix_b_ff     <= mix_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset
   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = hash_ff;

   // A string end only moves when the output slot can take it
   a_last_needs_slot: assert property (@(posedge clock) disable iff (reset)
      stage_take && stage_ctl.last_byte |-> out_free)
      else $error("string end taken while result slot busy");

   // Seeds restart after every string end
   a_seed_restart: assert property (@(posedge clock) disable iff (reset)
      stage_take && stage_ctl.last_byte |=>
         mix_a_ff == owh_pkg::SeedAStart && mix_b_ff == owh_pkg::SeedBStart)
      else $error("seeds not restored after string end");

   // Idle items leave the seeds alone
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      stage_take && !stage_ctl.has_byte && !stage_ctl.last_byte |=>
         $stable(mix_a_ff) && $stable(mix_b_ff))
      else $error("idle item changed seeds");

   // A new result appears only after a string end was taken
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage_take && stage_ctl.last_byte))
      else $error("result raised without a string end");

endmodule

>>> design/one_way_string_hash_top.sv
// one_way_string_hash_top: streaming table-driven one-way string hash.
// Instantiates owh_rom and owh_mix; depends on owh_pkg.
//
//   Channel  | Dir | Ports                       | Carries
//   req      | in  | req_tvalid/tready/tdata/... | one string byte, flags and hash kind
//   rsp      | out | rsp_tvalid/tready/tdata     | 32-bit hash of a finished string
//
// One item is accepted per cycle while the stage can move on; the table read is
// registered alongside the stage register, and the hash then enters the output register.
// The seed pair updates once for each byte, which allows the one-item rate.
// Reset is synchronous and restores the start seeds; the table is constant.
// A stalled result holds only string ends; other items keep flowing until one is held.
module one_way_string_hash_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic [3:0]  req_tuser,   // [0] has_byte, [3:1] hash_kind
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] hash_value
);

   logic                             stage_valid_ff, stage_valid_in;
   owh_pkg::stage_ctl_type           stage_ctl_ff, stage_ctl_in;
   logic                             stage_take;
   logic                             req_fire;
   logic [owh_pkg::KindWidth-1:0]    kind;
   logic [owh_pkg::ByteWidth-1:0]    ch;
   logic [owh_pkg::RomAddrWidth-1:0] rom_addr;
   owh_pkg::rom_word_type            rom_word;

   // Fold, clamp and form the table address
   always_comb begin
      ch       = owh_pkg::fold_upper(req_tdata);
      kind     = owh_pkg::clamp_kind(req_tuser[3:1]);
      rom_addr = owh_pkg::RomAddrWidth'({kind, ch});
   end

   // Accept when the stage is empty or moving on
   assign req_tready = !stage_valid_ff || stage_take;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_ctl_in   = stage_ctl_ff;
      if (req_fire) begin
         stage_valid_in         = 1'b1;
         stage_ctl_in.has_byte  = req_tuser[0];
         stage_ctl_in.last_byte = req_tlast;
         stage_ctl_in.ch        = ch;
      end else if (stage_take) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ctl_ff <= stage_ctl_in;
   end

   owh_rom u_rom (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (rom_addr),
      .rd_data (rom_word)
   );

   owh_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid_ff),
      .stage_ctl   (stage_ctl_ff),
      .rom_word    (rom_word),
      .stage_take  (stage_take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

>>> sim/one_way_string_hash_checker.sv
// one_way_string_hash_checker: watches the req and rsp streams of the string hash,
// predicts each string's hash from its own scramble table and seed pair, and compares.
// Depends on owh_pkg for table geometry, seed start values and generator constants.
module one_way_string_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic [3:0]  req_tuser,   // [0] has_byte, [3:1] hash_kind
   input  logic        req_tlast,   // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] hash_value
   output int          mismatches,
   output int          hashes_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] scramble_words [owh_pkg::RomWords];
   logic [31:0] seed_a;
   logic [31:0] seed_b;
   logic [31:0] hashes_due [$];
   int          mismatch_total;

   // Fill the table: two generator steps per word, high half first
   initial begin
      logic [31:0] gen;
      logic [31:0] upper;
      gen = owh_pkg::GenStart;
      for (int col = 0; col < 256; col++) begin
         for (int row = 0; row < owh_pkg::HashKinds; row++) begin
            gen   = (gen * owh_pkg::GenMul + owh_pkg::GenAdd) % owh_pkg::GenMod;
            upper = {gen[15:0], 16'h0000};
            gen   = (gen * owh_pkg::GenMul + owh_pkg::GenAdd) % owh_pkg::GenMod;
            scramble_words[row * 256 + col] = upper | {16'h0000, gen[15:0]};
         end
      end
   end

   always @(posedge clock) begin
      logic [31:0] want;
      logic [31:0] next_a;
      logic [31:0] next_b;
      logic [7:0]  folded;
      int          row;
      if (reset) begin
         seed_a = owh_pkg::SeedAStart;
         seed_b = owh_pkg::SeedBStart;
         hashes_due.delete();
      end else begin
         // Compare a delivered hash with the oldest one owed
         if (rsp_tvalid && rsp_tready) begin
            if (hashes_due.size() == 0) begin
               mismatch_total++;
               $display("%0t: unexpected hash, expected none, got %08h", $time, rsp_tdata);
            end else begin
               want = hashes_due.pop_front();
               if (rsp_tdata !== want) begin
                  mismatch_total++;
                  $display("%0t: hash mismatch, expected %08h, got %08h",
                           $time, want, rsp_tdata);
               end
            end
         end

         // Advance the seed pair on an accepted item
         if (req_tvalid && req_tready) begin
            row = int'(req_tuser[3:1]);
            if (row >= owh_pkg::HashKinds) begin
               row = owh_pkg::HashKinds - 1;
            end
            if (req_tuser[0]) begin
               folded = req_tdata;
               if (folded >= 8'h61 && folded <= 8'h7A) begin
                  folded = folded - 8'h20;
               end
               next_a = scramble_words[row * 256 + int'(folded)] ^ (seed_a + seed_b);
               next_b = 32'(folded) + next_a + seed_b + (seed_b << 5) + 32'd3;
               seed_a = next_a;
               seed_b = next_b;
            end
            // A string end owes the first seed, then both seeds restart
            if (req_tlast) begin
               hashes_due.push_back(seed_a);
               seed_a = owh_pkg::SeedAStart;
               seed_b = owh_pkg::SeedBStart;
            end
         end
      end
      mismatches  <= mismatch_total;
      hashes_owed <= hashes_due.size();
   end

endmodule

>>> sim/one_way_string_hash_top_tb.sv
// one_way_string_hash_top_tb: drives strings into one_way_string_hash_top under
// varying sender gaps and receiver stalls and reports the verdict.
// Depends on owh_pkg, one_way_string_hash_top and one_way_string_hash_checker.
module one_way_string_hash_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StringBytesTarget = 1600;
   localparam int PhaseItems        = 200;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic [3:0]  req_tuser  = 4'h0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   int mismatches;
   int hashes_owed;
   int items_sent      = 0;
   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;

   one_way_string_hash_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   one_way_string_hash_checker hash_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .hashes_owed (hashes_owed)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the result side at the current phase's rate
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // Hard stop in case the block hangs
   initial begin
      #400_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Offer one item, idling first at the sender rate; called and returns at a falling edge
   task automatic offer_item(input logic [7:0] byte_val, input logic has_byte,
                             input logic last_byte, input logic [2:0] kind);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= byte_val;
      req_tuser  <= {kind, has_byte};
      req_tlast  <= last_byte;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (has_byte || last_byte) begin
         items_sent++;
      end
   endtask

   initial begin
      int         phase;
      int         str_len;
      logic [2:0] kind;
      logic [2:0] item_kind;
      logic [7:0] byte_val;
      bit         kind_drifts;
      bit         ends_on_byte;
      bit         is_last;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty string, idle items, folding edges, every kind
      offer_item(8'h00, 1'b0, 1'b1, 3'd0);
      offer_item(8'h00, 1'b0, 1'b0, 3'd0);
      offer_item(8'hFF, 1'b0, 1'b0, 3'd7);
      offer_item(8'h00, 1'b1, 1'b1, 3'd0);
      offer_item(8'hFF, 1'b1, 1'b1, 3'd1);
      offer_item(8'h61, 1'b1, 1'b1, 3'd2);
      offer_item(8'h7A, 1'b1, 1'b1, 3'd3);
      offer_item(8'h41, 1'b1, 1'b1, 3'd4);
      offer_item(8'h5A, 1'b1, 1'b1, 3'd5);
      offer_item(8'h60, 1'b1, 1'b1, 3'd6);
      offer_item(8'h7B, 1'b1, 1'b1, 3'd7);
      // Zero byte inside a string, end marked without a byte
      offer_item(8'h61, 1'b1, 1'b0, 3'd4);
      offer_item(8'h62, 1'b1, 1'b0, 3'd4);
      offer_item(8'h00, 1'b1, 1'b0, 3'd4);
      offer_item(8'h63, 1'b1, 1'b0, 3'd4);
      offer_item(8'h00, 1'b0, 1'b1, 3'd4);
      // Same string in upper case, end carried on the last byte
      offer_item(8'h41, 1'b1, 1'b0, 3'd4);
      offer_item(8'h42, 1'b1, 1'b0, 3'd4);
      offer_item(8'h00, 1'b1, 1'b0, 3'd4);
      offer_item(8'h43, 1'b1, 1'b1, 3'd4);

      // Random strings, rotating through the idle and stall phases
      while (items_sent < StringBytesTarget) begin
         phase = (items_sent / PhaseItems) % 4;
         case (phase)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         str_len = ($urandom_range(15, 0) == 0) ? $urandom_range(40, 0)
                                                : $urandom_range(12, 0);
         kind = ($urandom_range(9, 0) == 0) ? 3'($urandom_range(7, 5))
                                           : 3'($urandom_range(4, 0));
         kind_drifts  = ($urandom_range(19, 0) == 0);
         ends_on_byte = ($urandom_range(1, 0) == 1);
         for (int i = 0; i < str_len; i++) begin
            // Drop in an idle item now and then
            if ($urandom_range(15, 0) == 0) begin
               offer_item(8'($urandom_range(255, 0)), 1'b0, 1'b0, kind);
            end
            byte_val  = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(8'h7A, 8'h61))
                                                   : 8'($urandom_range(255, 0));
            item_kind = kind_drifts ? 3'($urandom_range(7, 0)) : kind;
            is_last   = ends_on_byte && (i == str_len - 1);
            offer_item(byte_val, 1'b1, is_last, item_kind);
         end
         if (!ends_on_byte || str_len == 0) begin
            offer_item(8'($urandom_range(255, 0)), 1'b0, 1'b1, kind);
         end
      end
      req_tvalid <= 1'b0;

      // Drain: wait for every owed hash, then let the streams settle
      @(posedge clock);
      while (hashes_owed != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0 && hashes_owed == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> files.f
design/owh_pkg.sv
design/owh_rom.sv
design/owh_mix.sv
design/one_way_string_hash_top.sv
sim/one_way_string_hash_checker.sv
sim/one_way_string_hash_top_tb.sv
